// File: rtl/bffe_pkg.sv
// bffe_pkg: sizes, opcodes, cell command and scan carry types for the
// bitmap find-first engine. Used by the cell, the cell chain and the top level.
// No dependencies.
package bffe_pkg;

  localparam int MAX_BITS   = 1024;
  localparam int WORD_BITS  = 64;
  localparam int NUM_WORDS  = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int BIT_IDX_W  = $clog2(WORD_BITS);
  localparam int WORD_IDX_W = $clog2(NUM_WORDS);
  localparam int POS_W      = $clog2(MAX_BITS);
  localparam int LEN_W      = $clog2(MAX_BITS + 1);

  // Operation codes
  typedef enum logic [2:0] {
    OP_TEST       = 3'd0,
    OP_SET        = 3'd1,
    OP_CLEAR      = 3'd2,
    OP_TEST_SET   = 3'd3,
    OP_TEST_CLEAR = 3'd4,
    OP_FIND_ZERO  = 3'd5,
    OP_FIND_SET   = 3'd6,
    OP_FILL       = 3'd7
  } op_t;

  // Write command broadcast to every cell
  typedef struct packed {
    logic                  bit_wr;
    logic                  bit_val;
    logic                  fill_wr;
    logic                  fill_val;
    logic [WORD_IDX_W-1:0] word_sel;
    logic [BIT_IDX_W-1:0]  bit_sel;
  } cmd_t;

  // Running search result handed from cell to cell
  typedef struct packed {
    logic             zero_found;
    logic [POS_W-1:0] zero_pos;
    logic             set_found;
    logic [POS_W-1:0] set_pos;
  } scan_t;

  // Lowest set bit of a word: {found, position}
  function automatic logic [BIT_IDX_W:0] lowest_one(input logic [WORD_BITS-1:0] v);
    logic [BIT_IDX_W:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = {1'b1, BIT_IDX_W'(i)};
      end
    end
    return r;
  endfunction

endpackage

// File: rtl/bffe_cell.sv
// bffe_cell: one bitmap word with its write logic and one stage of the
// first-zero / first-set search chain.
// Depends on bffe_pkg.
module bffe_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [bffe_pkg::WORD_IDX_W-1:0] cell_id,
  input  logic [bffe_pkg::LEN_W-1:0]     len,
  input  bffe_pkg::cmd_t                 cmd,
  input  bffe_pkg::scan_t                carry_in,
  output bffe_pkg::scan_t                carry_out,
  output logic                           rd_bit
);
  import bffe_pkg::*;

  logic [WORD_BITS-1:0] word;
  logic [LEN_W-1:0]     base;
  logic [LEN_W-1:0]     base_end;
  logic [LEN_W-1:0]     rem;
  logic                 in_use;
  logic                 full_word;
  logic                 selected;
  logic [WORD_BITS-1:0] mask;
  logic [BIT_IDX_W:0]   zero_hit;
  logic [BIT_IDX_W:0]   set_hit;
  scan_t                carry_next;

  // Which bits of this word lie below the length
  assign base      = LEN_W'({cell_id, BIT_IDX_W'(0)});
  assign base_end  = base + LEN_W'(WORD_BITS);
  assign rem       = len - base;
  assign in_use    = len > base;
  assign full_word = len >= base_end;

  always_comb begin
    if (full_word) begin
      mask = '1;
    end else if (in_use) begin
      mask = ~({WORD_BITS{1'b1}} << rem[BIT_IDX_W-1:0]);
    end else begin
      mask = '0;
    end
  end

  // Addressed bit read, OR-combined across the chain
  assign selected = cmd.word_sel == cell_id;
  assign rd_bit   = selected & word[cmd.bit_sel];

  // Word update: single-bit write or fill
  always_ff @(posedge clk) begin
    if (rst) begin
      word <= '0;
    end else if (cmd.fill_wr && in_use) begin
      word <= cmd.fill_val ? {WORD_BITS{1'b1}} : {WORD_BITS{1'b0}};
    end else if (cmd.bit_wr && selected) begin
      word[cmd.bit_sel] <= cmd.bit_val;
    end
  end

  // Search stage: lower cells win, else take this word's first hit
  assign zero_hit = lowest_one(~word & mask);
  assign set_hit  = lowest_one(word & mask);

  always_comb begin
    carry_next = carry_in;
    if (!carry_in.zero_found) begin
      carry_next.zero_found = zero_hit[BIT_IDX_W];
      carry_next.zero_pos   = {cell_id, zero_hit[BIT_IDX_W-1:0]};
    end
    if (!carry_in.set_found) begin
      carry_next.set_found = set_hit[BIT_IDX_W];
      carry_next.set_pos   = {cell_id, set_hit[BIT_IDX_W-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carry_out <= '0;
    end else begin
      carry_out <= carry_next;
    end
  end

endmodule

// File: rtl/bffe_chain.sv
// bffe_chain: the row of bitmap cells, word 0 at the head of the search
// chain, and the OR of the addressed-bit reads.
// Depends on bffe_pkg and bffe_cell.
module bffe_chain (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [bffe_pkg::LEN_W-1:0] len,
  input  bffe_pkg::cmd_t             cmd,
  output bffe_pkg::scan_t            scan_out,
  output logic                       rd_bit
);
  import bffe_pkg::*;

  scan_t                carry [NUM_WORDS+1];
  logic [NUM_WORDS-1:0] rd_bits;

  assign carry[0] = '0;

  for (genvar k = 0; k < NUM_WORDS; k++) begin : g_cell
    bffe_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cell_id   (WORD_IDX_W'(k)),
      .len       (len),
      .cmd       (cmd),
      .carry_in  (carry[k]),
      .carry_out (carry[k+1]),
      .rd_bit    (rd_bits[k])
    );
  end

  assign scan_out = carry[NUM_WORDS];
  assign rd_bit   = |rd_bits;

endmodule

// File: rtl/bitmap_find_first_engine_core.sv
// bitmap_find_first_engine_core: bitmap of 16 x 64-bit cells with test/set/
// clear, find-first-zero/set and fill. An item is applied in the operation
// state, then the search result ripples one cell per cycle down the chain in
// the scan state, then the result load waits for the output register to be
// free. No new item is taken until that load. Synchronous reset clears the
// bitmap, sets length to 1024 and empties the output register.
module bitmap_find_first_engine_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write_enable,
  input  logic [bffe_pkg::LEN_W-1:0] cfg_write_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [2:0]                 opcode,
  input  logic [bffe_pkg::POS_W-1:0] bit_index,
  input  logic                       fill_ones,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       prior_bit,
  output logic [bffe_pkg::POS_W-1:0] found_position,
  output logic                       found,
  output logic                       map_full,
  output logic                       map_empty,
  output logic                       index_out_of_range
);
  import bffe_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_OP     = 4'b0010,
    S_SCAN   = 4'b0100,
    S_RESULT = 4'b1000
  } state_t;

  state_t                state, state_next;
  logic [LEN_W-1:0]      bitmap_length;
  logic [LEN_W-1:0]      len_used;
  op_t                   op_q;
  logic [POS_W-1:0]      idx_q;
  logic                  fill_q;
  logic [WORD_IDX_W-1:0] scan_cnt;
  logic                  prior_q;
  logic                  oor_q;
  logic                  is_bit_op;
  logic                  bit_val;
  logic                  oor;
  logic                  out_load;
  cmd_t                  cmd;
  scan_t                 scan_res;
  logic                  rd_bit;

  // Length register, clamped on use
  always_ff @(posedge clk) begin
    if (rst) begin
      bitmap_length <= LEN_W'(1024);
    end else if (cfg_write_enable) begin
      bitmap_length <= cfg_write_data;
    end
  end

  assign len_used = (bitmap_length > LEN_W'(MAX_BITS)) ? LEN_W'(MAX_BITS) : bitmap_length;

  // Decode of the held operation
  always_comb begin
    is_bit_op = 1'b0;
    bit_val   = 1'b0;
    case (op_q) inside
      OP_TEST, OP_TEST_SET, OP_TEST_CLEAR, OP_SET, OP_CLEAR: is_bit_op = 1'b1;
      default: is_bit_op = 1'b0;
    endcase
    case (op_q) inside
      OP_SET, OP_TEST_SET: bit_val = 1'b1;
      default: bit_val = 1'b0;
    endcase
  end

  assign oor          = LEN_W'(idx_q) >= len_used;
  assign cmd.bit_wr   = (state == S_OP) && is_bit_op && !oor && (op_q != OP_TEST);
  assign cmd.bit_val  = bit_val;
  assign cmd.fill_wr  = (state == S_OP) && (op_q == OP_FILL);
  assign cmd.fill_val = fill_q;
  assign cmd.word_sel = idx_q[POS_W-1:BIT_IDX_W];
  assign cmd.bit_sel  = idx_q[BIT_IDX_W-1:0];

  bffe_chain u_chain (
    .clk      (clk),
    .rst      (rst),
    .len      (len_used),
    .cmd      (cmd),
    .scan_out (scan_res),
    .rd_bit   (rd_bit)
  );

  assign in_ready = state == S_IDLE;
  assign out_load = (state == S_RESULT) && (!out_valid || out_ready);

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_OP;
      S_OP:     state_next = S_SCAN;
      S_SCAN:   if (scan_cnt == WORD_IDX_W'(NUM_WORDS - 1)) state_next = S_RESULT;
      S_RESULT: if (out_load) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      scan_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_SCAN) begin
        scan_cnt <= scan_cnt + 1'b1;
      end else begin
        scan_cnt <= '0;
      end
    end
  end

  // Item capture and bit-op results
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q   <= op_t'(opcode);
      idx_q  <= bit_index;
      fill_q <= fill_ones;
    end
    if (state == S_OP) begin
      prior_q <= is_bit_op && !oor && rd_bit;
      oor_q   <= is_bit_op && oor;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      prior_bit          <= prior_q;
      index_out_of_range <= oor_q;
      map_full           <= !scan_res.zero_found;
      map_empty          <= !scan_res.set_found;
      if (op_q == OP_FIND_ZERO && scan_res.zero_found) begin
        found          <= 1'b1;
        found_position <= scan_res.zero_pos;
      end else if (op_q == OP_FIND_SET && scan_res.set_found) begin
        found          <= 1'b1;
        found_position <= scan_res.set_pos;
      end else begin
        found          <= 1'b0;
        found_position <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_accept_to_op: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_OP))
    else $error("accepted item did not enter the operation cycle");

  a_op_to_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_OP) |=> (state == S_SCAN && scan_cnt == '0))
    else $error("scan did not start from the head of the chain");

  a_found_consistent: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found) |-> (!map_full || !map_empty))
    else $error("find reported a hit on a map flagged full and empty");

  a_oor_no_prior: assert property (@(posedge clk) disable iff (rst)
    (out_valid && index_out_of_range) |-> !prior_bit)
    else $error("out-of-range operation reported a prior bit");
`endif

endmodule
